@@ rtl/u2l_pkg.sv @@
`timescale 1ns / 1ps

package u2l_pkg;

	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int UD_W = 19;

	localparam logic [7:0] LEAD_MIN = 8'd128;
	localparam logic [7:0] LEAD3_MIN = 8'd224;

	localparam logic signed [UD_W-1:0] CP_LATIN1_END = UD_W'(256);
	localparam logic signed [UD_W-1:0] CP_LSQUO = UD_W'(32'h2018);
	localparam logic signed [UD_W-1:0] CP_RSQUO = UD_W'(32'h2019);
	localparam logic signed [UD_W-1:0] CP_LDQUO = UD_W'(32'h201c);
	localparam logic signed [UD_W-1:0] CP_RDQUO = UD_W'(32'h201d);
	localparam logic signed [UD_W-1:0] CP_ENDASH = UD_W'(32'h2013);
	localparam logic signed [UD_W-1:0] CP_EMDASH = UD_W'(32'h2014);
	localparam logic signed [UD_W-1:0] CP_EURO = UD_W'(32'h20ac);
	localparam logic signed [UD_W-1:0] CP_ARROW = UD_W'(32'h27a2);
	localparam logic signed [UD_W-1:0] CP_LOZENGE = UD_W'(32'h25ca);
	localparam logic signed [UD_W-1:0] CP_PUA_F076 = UD_W'(32'hf076);
	localparam logic signed [UD_W-1:0] CP_PUA_F0A7 = UD_W'(32'hf0a7);
	localparam logic signed [UD_W-1:0] CP_PUA_F0B7 = UD_W'(32'hf0b7);
	localparam logic signed [UD_W-1:0] CP_BULLET = UD_W'(32'h2022);
	localparam logic signed [UD_W-1:0] CP_ELLIPSIS = UD_W'(32'h2026);

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_APOS = 8'h27;
	localparam logic [7:0] CH_DASH = 8'h2d;
	localparam logic [7:0] CH_DOT = 8'h2e;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_CURRENCY = 8'ha4;
	localparam logic [7:0] CH_MIDDOT = 8'hb7;

	localparam logic [1:0] DOT_LAST = 2'd2;

	typedef enum logic [2:0] {
		PH_LEAD   = 3'b001,
		PH_SECOND = 3'b010,
		PH_THIRD  = 3'b100
	} phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic       dots;
		logic       str_end;
		logic       trunc;
	} cmd_t;

	function automatic cmd_t classify(input logic signed [UD_W-1:0] ud);
		cmd_t c;
		c.data = ud[7:0];
		c.dots = 1'b0;
		c.str_end = 1'b0;
		c.trunc = 1'b0;
		if (ud >= CP_LATIN1_END) begin
			case (ud) inside
				CP_LDQUO, CP_RDQUO: c.data = CH_DQUOTE;
				CP_LSQUO, CP_RSQUO: c.data = CH_APOS;
				CP_ENDASH, CP_EMDASH: c.data = CH_DASH;
				CP_EURO: c.data = CH_CURRENCY;
				CP_ARROW, CP_LOZENGE, CP_PUA_F076, CP_PUA_F0A7, CP_PUA_F0B7,
				CP_BULLET: c.data = CH_MIDDOT;
				CP_ELLIPSIS: begin
					c.data = CH_DOT;
					c.dots = 1'b1;
				end
				default: c.data = CH_SPACE;
			endcase
		end
		return c;
	endfunction

endpackage

@@ rtl/u2l_in_if.sv @@
`timescale 1ns / 1ps

interface u2l_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

@@ rtl/u2l_out_if.sv @@
`timescale 1ns / 1ps

interface u2l_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       string_end;
	logic       truncated;

	modport source (output valid, output out_byte, output run_last, output string_end,
		output truncated, input ready);
	modport sink (input valid, input out_byte, input run_last, input string_end,
		input truncated, output ready);
endinterface

@@ rtl/u2l_front.sv @@
`timescale 1ns / 1ps

module u2l_front (
	input  logic            clk,
	input  logic            arst_n,
	u2l_in_if.sink          upstream,
	input  logic            q_full,
	output logic            push,
	output u2l_pkg::cmd_t   cmd
);
	import u2l_pkg::*;

	phase_t     phase_q, phase_d;
	logic [7:0] lead_q;
	logic [7:0] second_q;
	logic       accept;
	logic       emit;
	logic       load_lead;
	logic       load_second;
	logic [7:0] c;

	logic signed [UD_W-1:0] lead_s, second_s, byte_s, ud2, ud3;

	assign upstream.ready = !q_full;
	assign accept = upstream.valid && upstream.ready;
	assign c = upstream.in_byte;

	assign lead_s = $signed({{(UD_W-8){1'b0}}, lead_q});
	assign second_s = $signed({{(UD_W-8){1'b0}}, second_q});
	assign byte_s = $signed({{(UD_W-8){1'b0}}, c});

	assign ud2 = ((lead_s - UD_W'(192)) <<< 6) + (byte_s - UD_W'(128));
	assign ud3 = ((lead_s - UD_W'(224)) <<< 12) + ((second_s - UD_W'(128)) <<< 6)
		+ (byte_s - UD_W'(128));

	always_comb begin
		phase_d = phase_q;
		emit = 1'b0;
		load_lead = 1'b0;
		load_second = 1'b0;
		cmd = '{data: c, dots: 1'b0, str_end: 1'b0, trunc: 1'b0};
		unique case (phase_q)
			PH_SECOND: begin
				if (c == CH_NUL) begin
					emit = 1'b1;
					cmd = '{data: CH_NUL, dots: 1'b0, str_end: 1'b1, trunc: 1'b1};
					phase_d = PH_LEAD;
				end else if (lead_q < LEAD3_MIN) begin
					emit = 1'b1;
					cmd = classify(ud2);
					phase_d = PH_LEAD;
				end else begin
					load_second = 1'b1;
					phase_d = PH_THIRD;
				end
			end
			PH_THIRD: begin
				emit = 1'b1;
				phase_d = PH_LEAD;
				if (c == CH_NUL) begin
					cmd = '{data: CH_NUL, dots: 1'b0, str_end: 1'b1, trunc: 1'b1};
				end else begin
					cmd = classify(ud3);
				end
			end
			default: begin
				phase_d = PH_LEAD;
				if (c == CH_NUL) begin
					emit = 1'b1;
					cmd = '{data: CH_NUL, dots: 1'b0, str_end: 1'b1, trunc: 1'b0};
				end else if (c < LEAD_MIN) begin
					emit = 1'b1;
				end else begin
					load_lead = 1'b1;
					phase_d = PH_SECOND;
				end
			end
		endcase
	end

	assign push = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
		end else if (accept) begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && load_lead) begin
			lead_q <= c;
		end
		if (accept && load_second) begin
			second_q <= c;
		end
	end

	a_zero_resyncs: assert property (@(posedge clk) disable iff (!arst_n)
		accept && c == CH_NUL |=> phase_q == PH_LEAD)
		else $error("zero byte did not return the decoder to the lead phase");

	a_trunc_needs_seq: assert property (@(posedge clk) disable iff (!arst_n)
		push && cmd.trunc |-> phase_q != PH_LEAD && cmd.str_end)
		else $error("truncation flagged outside a multibyte sequence");
endmodule

@@ rtl/u2l_queue.sv @@
`timescale 1ns / 1ps

module u2l_queue #(
	parameter int DEPTH = u2l_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  u2l_pkg::cmd_t   wr_cmd,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output u2l_pkg::cmd_t   head
);
	import u2l_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = count_q == CNT_W'(DEPTH);
	assign not_empty = count_q != '0;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> not_empty)
		else $error("queue read while empty");
endmodule

@@ rtl/u2l_back.sv @@
`timescale 1ns / 1ps

module u2l_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            not_empty,
	input  u2l_pkg::cmd_t   head,
	output logic            pop,
	u2l_out_if.source       downstream
);
	import u2l_pkg::*;

	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       end_q;
	logic       trunc_q;
	logic [1:0] dot_cnt_q;
	logic       load;
	logic       take;
	logic       final_dot;

	assign load = !valid_q || downstream.ready;
	assign take = load && not_empty;
	assign final_dot = dot_cnt_q == DOT_LAST;
	assign pop = take && (!head.dots || final_dot);

	assign downstream.valid = valid_q;
	assign downstream.out_byte = byte_q;
	assign downstream.run_last = last_q;
	assign downstream.string_end = end_q;
	assign downstream.truncated = trunc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			dot_cnt_q <= '0;
		end else begin
			if (load) begin
				valid_q <= not_empty;
			end
			if (take && head.dots) begin
				dot_cnt_q <= final_dot ? 2'd0 : dot_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_q <= head.data;
			last_q <= !head.dots || final_dot;
			end_q <= head.str_end;
			trunc_q <= head.trunc;
		end
	end

	a_dot_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		dot_cnt_q != 2'd3)
		else $error("ellipsis counter out of range");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && end_q |-> last_q && byte_q == CH_NUL)
		else $error("terminator result not marked as last");
endmodule

@@ rtl/utf8_to_latin1_transliterator.sv @@
`timescale 1ns / 1ps
// The decoder writes each result into the command queue; the result stage then registers it.
// Throughput: one input byte per cycle unless the queue is full; one result per cycle while downstream is ready.
// An ellipsis occupies the result side for three results, one per dot; the command queue between the
// decoder and the result stage absorbs this, and input stalls only when that queue fills.
// Reset is asynchronous and active low; it clears the phase, the queue and the output valid.

module utf8_to_latin1_transliterator #(
	parameter int QUEUE_DEPTH = u2l_pkg::QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	u2l_in_if.sink     upstream,
	u2l_out_if.source  downstream
);
	import u2l_pkg::*;

	logic q_full;
	logic q_push;
	logic q_pop;
	logic q_not_empty;
	cmd_t q_wr_cmd;
	cmd_t q_head;

	u2l_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.upstream (upstream),
		.q_full   (q_full),
		.push     (q_push),
		.cmd      (q_wr_cmd)
	);

	u2l_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wr_cmd    (q_wr_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	u2l_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.not_empty  (q_not_empty),
		.head       (q_head),
		.pop        (q_pop),
		.downstream (downstream)
	);
endmodule
